// ----- rtl/core/ikepc_pkg.sv -----
// ----------------------------------------------------------------------------
// ikepc_pkg
// Types and constants shared by the IKEv2 payload chain parser core.
// ----------------------------------------------------------------------------
package ikepc_pkg;

	localparam int MAX_PAYLOADS_DEF = 32;
	localparam int MAX_BYTES_DEF    = 65535;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam logic [15:0] HDR_BYTES = 16'd28;
	localparam logic [15:0] GEN_HDR   = 16'd4;

	localparam logic [15:0] POS_FIRST_TYPE = 16'd16;
	localparam logic [15:0] POS_EXCHANGE   = 16'd18;
	localparam logic [15:0] POS_FLAGS      = 16'd19;
	localparam logic [15:0] POS_MSGID_LO   = 16'd20;
	localparam logic [15:0] POS_MSGID_HI   = 16'd23;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_BADLEN   = 3'd4;
	localparam logic [2:0] ST_TOOLONG  = 3'd5;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  pl_type;
		logic [15:0] data_offset;
		logic [15:0] data_length;
		logic [4:0]  record_index;
		logic [2:0]  status;
		logic [5:0]  payload_count;
		logic [7:0]  exch_code;
		logic [7:0]  header_flags;
		logic [31:0] message_id;
		logic        last;
	} out_t;

	// one queued request: an optional record followed by an optional status
	typedef struct packed {
		logic rec_valid;
		logic stat_valid;
		out_t rec;
		out_t stat;
	} action_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/core/ikepc_front.sv -----
// ----------------------------------------------------------------------------
// ikepc_front
// Byte parser: captures the fixed header, walks the generic payload headers
// and queues record and status requests.
// ----------------------------------------------------------------------------
module ikepc_front import ikepc_pkg::*; #(
	parameter int MAX_PAYLOADS = MAX_PAYLOADS_DEF,
	parameter int MAX_BYTES    = MAX_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  in_t     in_data,
	input  q_stat_t q_stat,
	output logic    push,
	output action_t push_data
);

	localparam int RCW = $clog2(MAX_PAYLOADS + 1);

	typedef struct packed {
		logic active;
		logic trunc;
	} walk_t;

	logic [15:0]    pos_q, pos_n;
	logic           ovf_q, ovf_n;
	logic [31:0]    decl_q, decl_n;
	logic [7:0]     first_q, first_n;
	logic [7:0]     exch_q, exch_n;
	logic [7:0]     flags_q, flags_n;
	logic [31:0]    msgid_q, msgid_n;
	logic [7:0]     type_q, type_n;
	logic [16:0]    off_q, off_n;
	logic [7:0]     plen_hi_q, plen_hi_n;
	logic [7:0]     pend_q, pend_n;
	logic           walk_q, walk_n;
	logic [2:0]     err_q, err_n;
	logic [RCW-1:0] rec_q, rec_n;
	logic [15:0]    plen;
	logic [16:0]    off_sum;
	logic           rec_v;
	logic [2:0]     st;
	walk_t          cw;
	logic           accept;

	function automatic walk_t cont_walk(input logic [7:0] nt, input logic [16:0] off,
			input logic [31:0] decl);
		walk_t r;
		r = '0;
		if (nt == 8'd0 || {15'd0, off} >= decl) begin
			r = '0;
		end else if (off > 17'(MAX_BYTES)) begin
			r = '0;
		end else if ({15'd0, off} + {16'd0, GEN_HDR} > decl) begin
			r.trunc = 1'b1;
		end else begin
			r.active = 1'b1;
		end
		return r;
	endfunction

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign plen     = {plen_hi_q, in_data.data_byte};
	assign off_sum  = off_q + {1'b0, plen};

	always_comb begin
		pos_n     = pos_q;
		ovf_n     = ovf_q || (pos_q >= 16'(MAX_BYTES));
		decl_n    = decl_q;
		first_n   = first_q;
		exch_n    = exch_q;
		flags_n   = flags_q;
		msgid_n   = msgid_q;
		type_n    = type_q;
		off_n     = off_q;
		plen_hi_n = plen_hi_q;
		pend_n    = pend_q;
		walk_n    = walk_q;
		err_n     = err_q;
		rec_n     = rec_q;
		rec_v     = 1'b0;
		cw        = '0;
		if (!ovf_n) begin
			if (pos_q < HDR_BYTES) begin
				if (pos_q == POS_FIRST_TYPE) begin
					first_n = in_data.data_byte;
				end else if (pos_q == POS_EXCHANGE) begin
					exch_n = in_data.data_byte;
				end else if (pos_q == POS_FLAGS) begin
					flags_n = in_data.data_byte;
				end else if (pos_q >= POS_MSGID_LO && pos_q <= POS_MSGID_HI) begin
					msgid_n = {msgid_q[23:0], in_data.data_byte};
				end else if (pos_q > POS_MSGID_HI) begin
					decl_n = {decl_q[23:0], in_data.data_byte};
				end
				if (pos_q == HDR_BYTES - 16'd1) begin
					off_n  = {1'b0, HDR_BYTES};
					type_n = first_n;
					cw     = cont_walk(first_n, {1'b0, HDR_BYTES}, decl_n);
					walk_n = cw.active;
					if (cw.trunc) begin
						err_n = ST_TRUNC;
					end
				end
			end else if (walk_q && {1'b0, pos_q} >= off_q) begin
				if ({1'b0, pos_q} == off_q) begin
					pend_n = in_data.data_byte;
				end else if ({1'b0, pos_q} == off_q + 17'd2) begin
					plen_hi_n = in_data.data_byte;
				end else if ({1'b0, pos_q} == off_q + 17'd3) begin
					if (plen < GEN_HDR || {15'd0, off_sum} > decl_q) begin
						err_n  = ST_BADLEN;
						walk_n = 1'b0;
					end else begin
						if (rec_q < RCW'(MAX_PAYLOADS)) begin
							rec_v = 1'b1;
							rec_n = rec_q + RCW'(1);
						end
						type_n = pend_q;
						off_n  = off_sum;
						cw     = cont_walk(pend_q, off_sum, decl_q);
						walk_n = cw.active;
						if (cw.trunc) begin
							err_n = ST_TRUNC;
						end
					end
				end
			end
			pos_n = pos_q + 16'd1;
		end

		if (ovf_n) begin
			st = ST_TOOLONG;
		end else if (pos_n < HDR_BYTES) begin
			st = ST_SHORT;
		end else if (decl_n > {16'd0, pos_n}) begin
			st = ST_MISMATCH;
		end else begin
			st = err_n;
		end

		push_data.rec_valid          = rec_v;
		push_data.stat_valid         = in_data.last_byte;
		push_data.rec.result_kind    = KIND_RECORD;
		push_data.rec.pl_type        = type_q;
		push_data.rec.data_offset    = 16'(off_q + {1'b0, GEN_HDR});
		push_data.rec.data_length    = plen - GEN_HDR;
		push_data.rec.record_index   = 5'(rec_q);
		push_data.rec.status         = ST_OK;
		push_data.rec.payload_count  = 6'(rec_n);
		push_data.rec.exch_code      = exch_n;
		push_data.rec.header_flags   = flags_n;
		push_data.rec.message_id     = msgid_n;
		push_data.rec.last           = 1'b0;
		push_data.stat.result_kind   = KIND_STATUS;
		push_data.stat.pl_type       = first_n;
		push_data.stat.data_offset   = 16'd0;
		push_data.stat.data_length   = 16'd0;
		push_data.stat.record_index  = 5'd0;
		push_data.stat.status        = st;
		push_data.stat.payload_count = 6'(rec_n);
		push_data.stat.exch_code     = exch_n;
		push_data.stat.header_flags  = flags_n;
		push_data.stat.message_id    = msgid_n;
		push_data.stat.last          = 1'b1;
	end

	assign push = accept && (rec_v || in_data.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			ovf_q     <= 1'b0;
			decl_q    <= '0;
			first_q   <= '0;
			exch_q    <= '0;
			flags_q   <= '0;
			msgid_q   <= '0;
			type_q    <= '0;
			off_q     <= {1'b0, HDR_BYTES};
			plen_hi_q <= '0;
			pend_q    <= '0;
			walk_q    <= 1'b0;
			err_q     <= ST_OK;
			rec_q     <= '0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				pos_q     <= '0;
				ovf_q     <= 1'b0;
				decl_q    <= '0;
				first_q   <= '0;
				exch_q    <= '0;
				flags_q   <= '0;
				msgid_q   <= '0;
				type_q    <= '0;
				off_q     <= {1'b0, HDR_BYTES};
				plen_hi_q <= '0;
				pend_q    <= '0;
				walk_q    <= 1'b0;
				err_q     <= ST_OK;
				rec_q     <= '0;
			end else begin
				pos_q     <= pos_n;
				ovf_q     <= ovf_n;
				decl_q    <= decl_n;
				first_q   <= first_n;
				exch_q    <= exch_n;
				flags_q   <= flags_n;
				msgid_q   <= msgid_n;
				type_q    <= type_n;
				off_q     <= off_n;
				plen_hi_q <= plen_hi_n;
				pend_q    <= pend_n;
				walk_q    <= walk_n;
				err_q     <= err_n;
				rec_q     <= rec_n;
			end
		end
	end

endmodule

// ----- rtl/core/ikepc_queue.sv -----
// ----------------------------------------------------------------------------
// ikepc_queue
// Short request queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module ikepc_queue import ikepc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  action_t push_data,
	input  logic    pop,
	output action_t head,
	output q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	action_t         ent_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign head         = ent_q[rd_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= nxt_ptr(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/ikepc_back.sv -----
// ----------------------------------------------------------------------------
// ikepc_back
// Result sequencer: splits each queued request into its record and status
// results and drives the registered output channel.
// ----------------------------------------------------------------------------
module ikepc_back import ikepc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  action_t head,
	input  q_stat_t q_stat,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output out_t    out_data
);

	logic phase_q;
	logic load;
	logic emit_rec;

	assign load     = !q_stat.empty && (!out_valid || out_ready);
	assign emit_rec = head.rec_valid && !phase_q;
	assign pop      = load && (!emit_rec || !head.stat_valid);

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= emit_rec ? head.rec : head.stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				phase_q   <= emit_rec && head.stat_valid;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/ike_payload_chain_parser_core.sv -----
// ----------------------------------------------------------------------------
// ike_payload_chain_parser_core
// IKEv2 message payload chain parser, one byte per cycle while the request queue has room.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the request queue is not full; a byte
//   that yields a record and a status puts both on the output in turn, absorbed by the request queue.
// Path: each result is held in a request queue entry and then in the output register.
// Reset: arst_n clears all control state; after each status the parser
//   returns to its header state for the next message.
module ike_payload_chain_parser_core import ikepc_pkg::*; #(
	parameter int MAX_PAYLOADS = MAX_PAYLOADS_DEF,
	parameter int MAX_BYTES    = MAX_BYTES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic    push;
	logic    pop;
	action_t push_data;
	action_t head;
	q_stat_t q_stat;

	ikepc_front #(
		.MAX_PAYLOADS(MAX_PAYLOADS),
		.MAX_BYTES   (MAX_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data)
	);

	ikepc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	ikepc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ----- test/ike_payload_chain_checker.sv -----
// ----------------------------------------------------------------------------
// ike_payload_chain_checker
// Watches both channels of the IKEv2 payload chain parser, keeps its own
// model of the parse state, predicts the records and the message status for
// every accepted byte and compares each delivered result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ike_payload_chain_checker import ikepc_pkg::*; #(
	parameter int MAX_PAYLOADS = MAX_PAYLOADS_DEF,
	parameter int MAX_BYTES    = MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_t        out_data,
	output int unsigned errors,
	output int unsigned outstanding,
	output int unsigned checked
);

	out_t        parse_results[$];
	int unsigned mismatch_count = 0;
	int unsigned pending_count = 0;
	int unsigned compared_count = 0;

	logic [15:0] pos;
	logic        ovf;
	logic [31:0] decl_len;
	logic [7:0]  first_type;
	logic [7:0]  exch;
	logic [7:0]  flags;
	logic [31:0] msg_id;
	logic [7:0]  next_type;
	logic [31:0] chain_off;
	logic [15:0] plen;
	logic [7:0]  pend_type;
	logic        walking;
	logic [2:0]  err;
	logic [5:0]  rec_count;

	assign errors      = mismatch_count;
	assign outstanding = pending_count;
	assign checked     = compared_count;

	task automatic clear_message();
		pos        = '0;
		ovf        = 1'b0;
		decl_len   = '0;
		first_type = '0;
		exch       = '0;
		flags      = '0;
		msg_id     = '0;
		next_type  = '0;
		chain_off  = 32'(HDR_BYTES);
		plen       = '0;
		pend_type  = '0;
		walking    = 1'b0;
		err        = ST_OK;
		rec_count  = '0;
	endtask

	function automatic out_t make_result(input logic kind, input logic [7:0] ptype,
		input logic [15:0] doff, input logic [15:0] dlen, input logic [4:0] idx,
		input logic [2:0] st, input logic fin);
		out_t r;
		r.result_kind   = kind;
		r.pl_type       = ptype;
		r.data_offset   = doff;
		r.data_length   = dlen;
		r.record_index  = idx;
		r.status        = st;
		r.payload_count = rec_count;
		r.exch_code     = exch;
		r.header_flags  = flags;
		r.message_id    = msg_id;
		r.last          = fin;
		return r;
	endfunction

	// decide whether the chain goes on from chain_off with next_type
	task automatic advance_walk();
		walking = 1'b0;
		if (next_type != 8'd0 && chain_off < decl_len && chain_off <= MAX_BYTES) begin
			if (chain_off + GEN_HDR > decl_len)
				err = ST_TRUNC;
			else
				walking = 1'b1;
		end
	endtask

	task automatic take_byte(input logic [7:0] b, input logic fin);
		logic [15:0] p;
		logic [31:0] d;
		logic [2:0]  st;
		p = pos;
		if (p >= MAX_BYTES)
			ovf = 1'b1;
		if (!ovf) begin
			if (p < HDR_BYTES) begin
				if (p == POS_FIRST_TYPE)
					first_type = b;
				else if (p == POS_EXCHANGE)
					exch = b;
				else if (p == POS_FLAGS)
					flags = b;
				else if (p >= POS_MSGID_LO && p <= POS_MSGID_HI)
					msg_id = {msg_id[23:0], b};
				else if (p > POS_MSGID_HI)
					decl_len = {decl_len[23:0], b};
				if (p == HDR_BYTES - 16'd1) begin
					chain_off = 32'(HDR_BYTES);
					next_type = first_type;
					advance_walk();
				end
			end else if (walking && p >= chain_off) begin
				d = p - chain_off;
				if (d == 0) begin
					pend_type = b;
				end else if (d == 2) begin
					plen = {b, 8'h00};
				end else if (d == 3) begin
					plen = {plen[15:8], b};
					if (plen < GEN_HDR || chain_off + plen > decl_len) begin
						err = ST_BADLEN;
						walking = 1'b0;
					end else begin
						if (rec_count < MAX_PAYLOADS) begin
							rec_count++;
							parse_results.push_back(make_result(KIND_RECORD, next_type,
								16'(chain_off + GEN_HDR), plen - GEN_HDR, 5'(rec_count - 1),
								ST_OK, 1'b0));
						end
						next_type = pend_type;
						chain_off += plen;
						advance_walk();
					end
				end
			end
			pos = p + 16'd1;
		end
		if (fin) begin
			if (ovf)
				st = ST_TOOLONG;
			else if (pos < HDR_BYTES)
				st = ST_SHORT;
			else if (decl_len > pos)
				st = ST_MISMATCH;
			else
				st = err;
			parse_results.push_back(make_result(KIND_STATUS, first_type, '0, '0, '0, st, 1'b1));
			clear_message();
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input out_t got);
		out_t want;
		if (parse_results.size() == 0) begin
			$error("unexpected result: kind %0d type %0d status %0d",
				got.result_kind, got.pl_type, got.status);
			mismatch_count++;
		end else begin
			want = parse_results.pop_front();
			compared_count++;
			compare_field("result_kind", want.result_kind, got.result_kind);
			compare_field("pl_type", want.pl_type, got.pl_type);
			compare_field("data_offset", want.data_offset, got.data_offset);
			compare_field("data_length", want.data_length, got.data_length);
			compare_field("record_index", want.record_index, got.record_index);
			compare_field("status", want.status, got.status);
			compare_field("payload_count", want.payload_count, got.payload_count);
			compare_field("exch_code", want.exch_code, got.exch_code);
			compare_field("header_flags", want.header_flags, got.header_flags);
			compare_field("message_id", want.message_id, got.message_id);
			compare_field("last", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_message();
			parse_results.delete();
			pending_count = 0;
		end else begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (in_valid && in_ready)
				take_byte(in_data.data_byte, in_data.last_byte);
			pending_count = parse_results.size();
		end
	end

endmodule

// ----- test/ike_payload_chain_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// ike_payload_chain_parser_core_tb
// Feeds IKEv2 messages byte by byte into the payload chain parser: a short
// directed set of header and chain corner cases, then mostly well-formed
// random chains mixed with broken ones and noise. Both sides stall at
// random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ike_payload_chain_parser_core_tb import ikepc_pkg::*;;

	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_BYTES = 600;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	int unsigned errors;
	int unsigned outstanding;
	int unsigned checked;

	logic [7:0]  msg_bytes[$];
	bit          steady = 1'b0;
	bit          hold_off_req = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned msgs_sent = 0;

	ike_payload_chain_parser_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	ike_payload_chain_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (steady)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 16);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, last_byte: fin};
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message();
		int i;
		for (i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msgs_sent++;
	endtask

	task automatic pause_sender();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic put_header(input logic [7:0] first, input logic [31:0] decl,
		input bit plain, input logic [7:0] fill);
		int i;
		msg_bytes.delete();
		for (i = 0; i < HDR_BYTES - 4; i++) begin
			if (i == POS_FIRST_TYPE)
				msg_bytes.push_back(first);
			else
				msg_bytes.push_back(plain ? fill : 8'($urandom));
		end
		for (i = 0; i < 4; i++)
			msg_bytes.push_back(decl[8 * (3 - i) +: 8]);
	endtask

	task automatic set_declared(input logic [31:0] decl);
		int i;
		for (i = 0; i < 4; i++)
			msg_bytes[HDR_BYTES - 4 + i] = decl[8 * (3 - i) +: 8];
	endtask

	task automatic add_payload(input logic [7:0] nxt, input logic [15:0] hdr_len,
		input int data_count);
		msg_bytes.push_back(nxt);
		msg_bytes.push_back(8'($urandom));
		msg_bytes.push_back(hdr_len[15:8]);
		msg_bytes.push_back(hdr_len[7:0]);
		repeat (data_count) msg_bytes.push_back(8'($urandom));
	endtask

	task automatic make_random_message(input int mode);
		int          n;
		int          i;
		int          plen;
		int          total;
		int          bad_at;
		int          extra;
		int          cut;
		logic [7:0]  nxt;
		logic [15:0] hdr_len;
		logic [31:0] decl;
		if (mode >= 96) begin
			msg_bytes.delete();
			repeat ($urandom_range(1, 60)) msg_bytes.push_back(8'($urandom));
		end else begin
			n = (mode >= 88 && mode < 92) ? $urandom_range(33, 40) : $urandom_range(0, 6);
			bad_at = (mode >= 76 && mode < 82) ? $urandom_range(0, n) : -1;
			put_header((n > 0 || $urandom_range(1)) ? 8'($urandom_range(1, 255)) : 8'd0,
				'0, 1'b0, '0);
			total = 0;
			for (i = 0; i < n; i++) begin
				if (n > 32)
					plen = $urandom_range(4, 5);
				else if ($urandom_range(9) == 0)
					plen = $urandom_range(4, 60);
				else
					plen = $urandom_range(4, 16);
				nxt = (i == n - 1 && $urandom_range(9) < 7) ? 8'd0 : 8'($urandom_range(1, 255));
				hdr_len = 16'(plen);
				if (i == bad_at)
					hdr_len = $urandom_range(1) ? 16'($urandom_range(0, 3)) :
						16'($urandom_range(plen + 1, 65535));
				add_payload(nxt, hdr_len, plen - 4);
				total += plen;
			end
			decl = HDR_BYTES + total;
			if (mode < 60) begin
				if ($urandom_range(4) == 0) begin
					extra = $urandom_range(1, 12);
					decl += extra;
					repeat (extra) msg_bytes.push_back(8'($urandom));
				end
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
			end else if (mode < 68) begin
				decl += $urandom_range(1) ? $urandom_range(1, 8) : $urandom;
			end else if (mode < 76) begin
				decl = (total > 0) ? decl - $urandom_range(1, total) :
					$urandom_range(0, HDR_BYTES - 1);
			end else if (mode >= 92) begin
				decl = $urandom_range(0, HDR_BYTES);
			end
			set_declared(decl);
			if (mode >= 82 && mode < 88) begin
				cut = $urandom_range(1, msg_bytes.size() - 1);
				msg_bytes = msg_bytes[0:cut - 1];
			end
		end
	endtask

	initial begin
		int i;
		int msg_index;
		int unsigned random_start;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		msg_bytes.delete();
		msg_bytes.push_back(8'hFF);
		send_message();
		msg_bytes.delete();
		repeat (HDR_BYTES - 1) msg_bytes.push_back(8'($urandom));
		send_message();
		put_header(8'h00, 32'h0, 1'b1, 8'h00);
		send_message();
		put_header(8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
		send_message();
		put_header(8'hFF, 32'h0002_0000, 1'b1, 8'hFF);
		add_payload(8'hFF, 16'hFFFF, 0);
		send_message();
		put_header(8'h01, 32'd30, 1'b0, '0);
		repeat (2) msg_bytes.push_back(8'($urandom));
		send_message();
		put_header(8'h02, 32'd40, 1'b0, '0);
		add_payload(8'h00, 16'd2, 8);
		send_message();
		put_header(8'h03, 32'd40, 1'b0, '0);
		add_payload(8'h00, 16'h0020, 8);
		send_message();
		put_header(8'h04, 32'd40, 1'b0, '0);
		add_payload(8'h00, 16'd8, 4);
		repeat (7) msg_bytes.push_back(8'($urandom));
		send_message();
		put_header(8'h05, HDR_BYTES + 34 * 4, 1'b0, '0);
		for (i = 0; i < 34; i++)
			add_payload((i == 33) ? 8'h00 : 8'($urandom_range(1, 255)), 16'd4, 0);
		send_message();

		random_start = bytes_sent;
		msg_index = 0;
		while (bytes_sent < random_start + RANDOM_BYTES || msg_index < 10) begin
			if (msg_index == 5)
				pause_sender();
			steady = (msg_index >= 6 && msg_index < 10);
			if (msg_index == 2) begin
				hold_off_req = 1'b1;
				make_random_message(90);
			end else begin
				make_random_message($urandom_range(99));
			end
			send_message();
			msg_index++;
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (16) @(posedge clk);
		$display("run: %0d messages in %0d bytes: header, chain, record limit, length",
			msgs_sent, bytes_sent);
		$display("run: and buffer size corner cases; %0d results compared, %0d mismatches",
			checked, errors);
		if (errors == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ikepc_pkg.sv
rtl/core/ikepc_front.sv
rtl/core/ikepc_queue.sv
rtl/core/ikepc_back.sv
rtl/core/ike_payload_chain_parser_core.sv
test/ike_payload_chain_checker.sv
test/ike_payload_chain_parser_core_tb.sv
